@@ rtl/core/xcrc_pkg.sv @@
// Package of shared types, codes and the CRC-16 byte update for the XMODEM-CRC receiver.
package xcrc_pkg;

  localparam int BLOCK_BYTES_DEFAULT = 128;
  localparam int QUEUE_DEPTH = 4;

  // Protocol characters.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Input item kinds.
  localparam logic [1:0] EV_BYTE    = 2'd0;
  localparam logic [1:0] EV_TIMEOUT = 2'd1;
  localparam logic [1:0] EV_START   = 2'd2;
  localparam logic [1:0] EV_CANCEL  = 2'd3;

  // Result kinds.
  localparam logic [2:0] RK_PAYLOAD = 3'd0;
  localparam logic [2:0] RK_SEND    = 3'd1;
  localparam logic [2:0] RK_ACCEPT  = 3'd2;
  localparam logic [2:0] RK_REJECT  = 3'd3;
  localparam logic [2:0] RK_ENDED   = 3'd4;

  // End status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_CANCELLED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_BLOCK_COUNT   = 2'd0;
  localparam logic [1:0] REG_SKIP_CRC      = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;
  localparam logic [1:0] REG_CRC_LOW_FIRST = 2'd3;

  // One queued response: the group of results caused by one input item.
  typedef enum logic [2:0] {
    BND_PAYLOAD,  // one payload byte
    BND_NAK2,     // NAK, NAK
    BND_ACCEPT,   // accepted, ACK, ACK
    BND_REJECT,   // rejected, NAK, NAK
    BND_ABORT,    // CAN, CAN, ended
    BND_DONE      // ended with status ok
  } bundle_kind_t;

  typedef struct packed {
    bundle_kind_t kind;
    logic [7:0]   data;
    logic [6:0]   index;
    logic [15:0]  block;
    logic [7:0]   kept;
    logic [1:0]   status;
  } bundle_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/xcrc_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
interface xcrc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface xcrc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  payload_byte;
  logic [6:0]  payload_index;
  logic [7:0]  tx_byte;
  logic [15:0] block_number;
  logic [7:0]  kept_length;
  logic [1:0]  end_status;
  logic        last;
  modport source (output valid, output out_kind, output payload_byte, output payload_index,
                  output tx_byte, output block_number, output kept_length,
                  output end_status, output last, input ready);
  modport sink (input valid, input out_kind, input payload_byte, input payload_index,
                input tx_byte, input block_number, input kept_length,
                input end_status, input last, output ready);
endinterface

interface xcrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/xcrc_core.sv @@
// Receiver state machine: input register, frame tracking, CRC and verdicts.
module xcrc_core #(
  parameter int BLOCK_BYTES = xcrc_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  xcrc_item_if.sink         item,
  xcrc_cfg_if.sink          cfg,
  input  logic              room,
  output logic              push,
  output xcrc_pkg::bundle_t push_bundle
);
  import xcrc_pkg::*;

  localparam int FP_W = $clog2(BLOCK_BYTES + 5);
  localparam logic [FP_W-1:0] POS_BLK     = FP_W'(1);
  localparam logic [FP_W-1:0] POS_NBLK    = FP_W'(2);
  localparam logic [FP_W-1:0] POS_DATA    = FP_W'(3);
  localparam logic [FP_W-1:0] POS_CRC_FST = FP_W'(BLOCK_BYTES + 3);
  localparam logic [7:0]      KEPT_FULL   = 8'(BLOCK_BYTES);

  typedef enum logic [1:0] {PH_IDLE, PH_BLOCK, PH_EOT} phase_t;

  // Configuration registers.
  logic [15:0] block_count;
  logic        skip_crc;
  logic [7:0]  retry_limit;
  logic        crc_low_first;

  // Input register.
  logic       pend_valid;
  logic [1:0] pend_kind;
  logic [7:0] pend_byte;

  // Receiver state.
  phase_t          phase, phase_next;
  logic [FP_W-1:0] frame_position, frame_position_next;
  logic [15:0]     expected_block, expected_block_next;
  logic [7:0]      retry_count, retry_count_next;
  logic [15:0]     running_crc, running_crc_next;
  logic [15:0]     received_crc, received_crc_next;
  logic            header_ok, header_ok_next;
  logic [7:0]      last_nonzero_length, last_nonzero_length_next;
  logic            first_eot_seen, first_eot_seen_next;

  logic            do_retry;
  logic            do_open;
  logic [FP_W-1:0] data_idx;
  logic [15:0]     full_crc;
  logic            block_good;

  assign item.ready = room;
  assign cfg.ready  = 1'b1;

  assign data_idx = frame_position - POS_DATA;
  assign full_crc = received_crc | (crc_low_first ? {pend_byte, 8'h00} : {8'h00, pend_byte});
  assign block_good = header_ok && (skip_crc || full_crc == running_crc);

  always_comb begin
    phase_next               = phase;
    frame_position_next      = frame_position;
    expected_block_next      = expected_block;
    retry_count_next         = retry_count;
    running_crc_next         = running_crc;
    received_crc_next        = received_crc;
    header_ok_next           = header_ok;
    last_nonzero_length_next = last_nonzero_length;
    first_eot_seen_next      = first_eot_seen;
    do_retry                 = 1'b0;
    do_open                  = 1'b0;
    push                     = 1'b0;
    push_bundle              = '0;

    if (pend_valid) begin
      if (pend_kind == EV_START) begin
        expected_block_next = 16'd1;
        retry_count_next    = '0;
        do_open             = 1'b1;
        phase_next          = (block_count == '0) ? PH_EOT : PH_BLOCK;
        push                = 1'b1;
        push_bundle.kind    = BND_NAK2;
      end else if (phase == PH_IDLE) begin
        push = 1'b0;
      end else if (pend_kind == EV_TIMEOUT || pend_kind == EV_CANCEL) begin
        phase_next         = PH_IDLE;
        do_open            = 1'b1;
        push               = 1'b1;
        push_bundle.kind   = BND_ABORT;
        push_bundle.status = (pend_kind == EV_TIMEOUT) ? ST_TIMEOUT : ST_CANCELLED;
      end else if (phase == PH_BLOCK) begin
        frame_position_next = frame_position + 1'b1;
        if (frame_position == '0) begin
          header_ok_next = (pend_byte == CH_SOH);
        end else if (frame_position == POS_BLK) begin
          header_ok_next = header_ok && (pend_byte == expected_block[7:0]);
        end else if (frame_position == POS_NBLK) begin
          header_ok_next = header_ok && (pend_byte == ~expected_block[7:0]);
        end else if (frame_position < POS_CRC_FST) begin
          running_crc_next = crc16_byte(running_crc, pend_byte);
          if (pend_byte != '0) begin
            last_nonzero_length_next = 8'({1'b0, data_idx} + 1'b1);
          end
          push              = 1'b1;
          push_bundle.kind  = BND_PAYLOAD;
          push_bundle.data  = pend_byte;
          push_bundle.index = 7'(data_idx);
        end else if (frame_position == POS_CRC_FST) begin
          received_crc_next = crc_low_first ? {8'h00, pend_byte} : {pend_byte, 8'h00};
        end else if (!block_good) begin
          do_retry = 1'b1;
        end else begin
          push              = 1'b1;
          push_bundle.kind  = BND_ACCEPT;
          push_bundle.block = expected_block;
          push_bundle.kept  = (expected_block == block_count) ? last_nonzero_length
                                                              : KEPT_FULL;
          if (expected_block >= block_count) begin
            phase_next = PH_EOT;
          end
          expected_block_next = expected_block + 16'd1;
          retry_count_next    = '0;
          do_open             = 1'b1;
        end
      end else begin
        if (frame_position == '0) begin
          first_eot_seen_next = (pend_byte == CH_EOT);
          frame_position_next = POS_BLK;
        end else if (first_eot_seen && pend_byte == CH_EOT) begin
          phase_next         = PH_IDLE;
          do_open            = 1'b1;
          push               = 1'b1;
          push_bundle.kind   = BND_DONE;
          push_bundle.status = ST_OK;
        end else begin
          do_retry = 1'b1;
        end
      end

      if (do_retry) begin
        push = 1'b1;
        if (retry_count >= retry_limit) begin
          phase_next         = PH_IDLE;
          push_bundle.kind   = BND_ABORT;
          push_bundle.status = ST_EXHAUSTED;
        end else begin
          push_bundle.kind  = BND_REJECT;
          push_bundle.block = expected_block;
          retry_count_next  = retry_count + 8'd1;
        end
        do_open = 1'b1;
      end

      if (do_open) begin
        frame_position_next      = '0;
        running_crc_next         = '0;
        received_crc_next        = '0;
        header_ok_next           = 1'b0;
        last_nonzero_length_next = '0;
        first_eot_seen_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count         <= '0;
      skip_crc            <= 1'b0;
      retry_limit         <= 8'd10;
      crc_low_first       <= 1'b1;
      pend_valid          <= 1'b0;
      phase               <= PH_IDLE;
      frame_position      <= '0;
      expected_block      <= 16'd1;
      retry_count         <= '0;
      running_crc         <= '0;
      received_crc        <= '0;
      header_ok           <= 1'b0;
      last_nonzero_length <= '0;
      first_eot_seen      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_BLOCK_COUNT:   block_count   <= cfg.data;
          REG_SKIP_CRC:      skip_crc      <= cfg.data[0];
          REG_RETRY_LIMIT:   retry_limit   <= cfg.data[7:0];
          REG_CRC_LOW_FIRST: crc_low_first <= cfg.data[0];
          default:           skip_crc      <= skip_crc;
        endcase
      end
      pend_valid          <= item.valid && room;
      phase               <= phase_next;
      frame_position      <= frame_position_next;
      expected_block      <= expected_block_next;
      retry_count         <= retry_count_next;
      running_crc         <= running_crc_next;
      received_crc        <= received_crc_next;
      header_ok           <= header_ok_next;
      last_nonzero_length <= last_nonzero_length_next;
      first_eot_seen      <= first_eot_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && room) begin
      pend_kind <= item.kind;
      pend_byte <= item.rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_idle_cleared: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> frame_position == '0 && !first_eot_seen)
    else $error("frame state not cleared while idle");
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    pend_valid && pend_kind == EV_START |=> phase != PH_IDLE && frame_position == '0)
    else $error("start did not open a transfer");
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    pend_valid && phase == PH_IDLE && pend_kind != EV_START |-> !push)
    else $error("response produced while idle");
  a_eot_position: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EOT |-> frame_position <= POS_BLK)
    else $error("frame position out of range while waiting for EOT");
`endif
endmodule

@@ rtl/core/xcrc_out_queue.sv @@
// Response queue that expands each queued group into single result transfers.
module xcrc_out_queue #(
  parameter int DEPTH = xcrc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xcrc_pkg::bundle_t push_bundle,
  output logic              room,
  xcrc_result_if.source     result
);
  import xcrc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  bundle_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       sub;
  logic [1:0]       sub_final;
  bundle_t          head;
  logic             pop;
  logic             take;

  assign head   = entries[rd_ptr];
  // Two free groups cover the item in the input register plus one more.
  assign room   = count <= ROOM_MAX;
  assign take   = result.valid && result.ready;
  assign pop    = take && (sub == sub_final);

  always_comb begin
    result.valid         = count != '0;
    result.out_kind      = RK_SEND;
    result.payload_byte  = '0;
    result.payload_index = '0;
    result.tx_byte       = '0;
    result.block_number  = '0;
    result.kept_length   = '0;
    result.end_status    = '0;
    sub_final            = 2'd2;
    case (head.kind)
      BND_PAYLOAD: begin
        sub_final            = 2'd0;
        result.out_kind      = RK_PAYLOAD;
        result.payload_byte  = head.data;
        result.payload_index = head.index;
      end
      BND_NAK2: begin
        sub_final      = 2'd1;
        result.tx_byte = CH_NAK;
      end
      BND_ACCEPT: begin
        if (sub == 2'd0) begin
          result.out_kind     = RK_ACCEPT;
          result.block_number = head.block;
          result.kept_length  = head.kept;
        end else begin
          result.tx_byte = CH_ACK;
        end
      end
      BND_REJECT: begin
        if (sub == 2'd0) begin
          result.out_kind     = RK_REJECT;
          result.block_number = head.block;
        end else begin
          result.tx_byte = CH_NAK;
        end
      end
      BND_ABORT: begin
        if (sub == 2'd2) begin
          result.out_kind   = RK_ENDED;
          result.end_status = head.status;
        end else begin
          result.tx_byte = CH_CAN;
        end
      end
      BND_DONE: begin
        sub_final         = 2'd0;
        result.out_kind   = RK_ENDED;
        result.end_status = head.status;
      end
      default: begin
        sub_final = 2'd0;
      end
    endcase
    result.last = sub == sub_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
        sub    <= '0;
      end else if (take) begin
        sub <= sub + 2'd1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count < CNT_W'(DEPTH) || pop)
    else $error("response queue overflow");
  a_sub_needs_head: assert property (@(posedge clk) disable iff (rst)
    sub != '0 |-> count != '0 && sub <= sub_final)
    else $error("result position without a queued group");
  a_pop_clears_sub: assert property (@(posedge clk) disable iff (rst)
    pop |=> sub == '0)
    else $error("result position not cleared after group");
`endif
endmodule

@@ rtl/core/xmodem_crc_block_receiver.sv @@
// Top level of the XMODEM-CRC block receiver.
// An item is first captured in the input register, then judged and queued as one group;
// its first result is offered once that group has been written into the response queue.
// Throughput: one input item per cycle while the response queue holds at most DEPTH-2 groups;
// results leave one per cycle while result ready is high, three per verdict or abort.
// Reset (rst, synchronous): idle, expected block 1, registers at their defaults, queue empty.
module xmodem_crc_block_receiver #(
  parameter int BLOCK_BYTES = xcrc_pkg::BLOCK_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = xcrc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  xcrc_item_if.sink     item,
  xcrc_cfg_if.sink      cfg,
  xcrc_result_if.source result
);
  import xcrc_pkg::*;

  // The core turns each input item into at most one queued response group. It only takes an
  // input transfer when the queue has room for that group and for the one still in flight
  // in its input register, so no group is ever dropped.
  logic    room;
  logic    push;
  bundle_t push_bundle;

  xcrc_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .room       (room),
    .push       (push),
    .push_bundle(push_bundle)
  );

  // The queue expands each group into one, two or three result transfers and marks the
  // final one of each group with last.
  xcrc_out_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_bundle(push_bundle),
    .room       (room),
    .result     (result)
  );

`ifndef SYNTHESIS
  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg.ready)
    else $error("configuration channel stalled");
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result offered right after reset");
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> item.ready)
    else $error("input not ready after reset");
`endif
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the XMODEM-CRC block receiver: directed events, random transfers.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xcrc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int PAYLOAD_LEN   = BLOCK_BYTES_DEFAULT;
  localparam int FRAME_LEN     = PAYLOAD_LEN + 5;
  // Each item passes the block's input register before its group is queued, so a few
  // extra cycles are enough for an item that causes no result to drain out.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 260;

  // Receiver phase as tracked by the predictor.
  typedef enum logic [1:0] {RX_IDLE, RX_BLOCK, RX_EOT} rx_phase_t;

  // Ways in which a random frame may be damaged on the wire.
  typedef enum int {
    FR_GOOD, FR_BAD_SOH, FR_BAD_NUM, FR_BAD_CPL, FR_BAD_CRC, FR_SWAP_CRC,
    FR_CUT_TIMEOUT, FR_CUT_CANCEL, FR_CUT_START
  } frame_fault_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic [7:0]  tx_byte;
    logic [15:0] block_number;
    logic [7:0]  kept_length;
    logic [1:0]  end_status;
    logic        last;
  } reply_t;

  // Tracks the receiver's protocol state, predicts the replies that each input transfer
  // causes, and compares the replies that come out against them in order.
  class reply_predictor;
    logic [15:0] block_count;
    logic        skip_crc;
    logic [7:0]  retry_limit;
    logic        crc_low_first;

    rx_phase_t   phase;
    int          frame_pos;
    logic [15:0] expected_block;
    logic [7:0]  retry_count;
    logic [15:0] running_crc;
    logic [15:0] received_crc;
    logic        header_ok;
    logic [7:0]  last_nonzero;
    logic        first_eot;

    reply_t      due_replies[$];
    reply_t      batch[$];
    int          failures;

    function new();
      block_count    = 16'd0;
      skip_crc       = 1'b0;
      retry_limit    = 8'd10;
      crc_low_first  = 1'b1;
      phase          = RX_IDLE;
      expected_block = 16'd1;
      retry_count    = 8'd0;
      failures       = 0;
      open_block();
    endfunction

    // CRC-16 with polynomial 0x1021, fed one data bit at a time, MSB first.
    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      int          i;
      c = crc;
      for (i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void open_block();
      frame_pos    = 0;
      running_crc  = 16'd0;
      received_crc = 16'd0;
      header_ok    = 1'b0;
      last_nonzero = 8'd0;
      first_eot    = 1'b0;
    endfunction

    function void add(logic [2:0] kind_code, logic [7:0] data, logic [6:0] idx,
                      logic [7:0] tx, logic [15:0] blk, logic [7:0] kept,
                      logic [1:0] status);
      reply_t r;
      r = '{kind_code, data, idx, tx, blk, kept, status, 1'b0};
      batch.push_back(r);
    endfunction

    function void abort_transfer(logic [1:0] status);
      add(RK_SEND, 8'd0, 7'd0, CH_CAN, 16'd0, 8'd0, ST_OK);
      add(RK_SEND, 8'd0, 7'd0, CH_CAN, 16'd0, 8'd0, ST_OK);
      add(RK_ENDED, 8'd0, 7'd0, 8'd0, 16'd0, 8'd0, status);
      phase = RX_IDLE;
      open_block();
    endfunction

    function void retry();
      if (retry_count >= retry_limit) begin
        abort_transfer(ST_EXHAUSTED);
        return;
      end
      add(RK_REJECT, 8'd0, 7'd0, 8'd0, expected_block, 8'd0, ST_OK);
      add(RK_SEND, 8'd0, 7'd0, CH_NAK, 16'd0, 8'd0, ST_OK);
      add(RK_SEND, 8'd0, 7'd0, CH_NAK, 16'd0, 8'd0, ST_OK);
      retry_count = retry_count + 8'd1;
      open_block();
    endfunction

    function void finish_block();
      logic [7:0] kept;
      if (!(header_ok && (skip_crc || received_crc == running_crc))) begin
        retry();
        return;
      end
      // Only the final block is trimmed back to its last nonzero payload byte.
      kept = (expected_block == block_count) ? last_nonzero : 8'(PAYLOAD_LEN);
      add(RK_ACCEPT, 8'd0, 7'd0, 8'd0, expected_block, kept, ST_OK);
      add(RK_SEND, 8'd0, 7'd0, CH_ACK, 16'd0, 8'd0, ST_OK);
      add(RK_SEND, 8'd0, 7'd0, CH_ACK, 16'd0, 8'd0, ST_OK);
      if (expected_block >= block_count) phase = RX_EOT;
      expected_block = expected_block + 16'd1;
      retry_count    = 8'd0;
      open_block();
    endfunction

    function void block_byte(logic [7:0] b);
      int p;
      int idx;
      p         = frame_pos;
      frame_pos = p + 1;
      if (p == 0) begin
        header_ok = (b == CH_SOH);
      end else if (p == 1) begin
        header_ok = header_ok && (b == expected_block[7:0]);
      end else if (p == 2) begin
        header_ok = header_ok && (b == ~expected_block[7:0]);
      end else if (p < 3 + PAYLOAD_LEN) begin
        idx         = p - 3;
        running_crc = crc_step(running_crc, b);
        if (b != 8'd0) last_nonzero = 8'(idx + 1);
        add(RK_PAYLOAD, b, 7'(idx), 8'd0, 16'd0, 8'd0, ST_OK);
      end else if (p == 3 + PAYLOAD_LEN) begin
        received_crc = crc_low_first ? {8'd0, b} : {b, 8'd0};
      end else begin
        received_crc = received_crc | (crc_low_first ? {b, 8'd0} : {8'd0, b});
        finish_block();
      end
    endfunction

    function void eot_byte(logic [7:0] b);
      if (frame_pos == 0) begin
        first_eot = (b == CH_EOT);
        frame_pos = 1;
      end else if (first_eot && b == CH_EOT) begin
        phase = RX_IDLE;
        open_block();
        add(RK_ENDED, 8'd0, 7'd0, 8'd0, 16'd0, 8'd0, ST_OK);
      end else begin
        // A broken EOT pair is handled like a bad block.
        retry();
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_BLOCK_COUNT:   block_count   = value;
        REG_SKIP_CRC:      skip_crc      = value[0];
        REG_RETRY_LIMIT:   retry_limit   = value[7:0];
        REG_CRC_LOW_FIRST: crc_low_first = value[0];
        default: ;
      endcase
    endfunction

    // Notes one accepted input transfer. Returns 1 unless the block ignores it.
    function bit note_event(logic [1:0] ev_kind, logic [7:0] b);
      bit active;
      active = (phase != RX_IDLE) || (ev_kind == EV_START);
      batch.delete();
      if (ev_kind == EV_START) begin
        expected_block = 16'd1;
        retry_count    = 8'd0;
        open_block();
        phase = (block_count == 16'd0) ? RX_EOT : RX_BLOCK;
        add(RK_SEND, 8'd0, 7'd0, CH_NAK, 16'd0, 8'd0, ST_OK);
        add(RK_SEND, 8'd0, 7'd0, CH_NAK, 16'd0, 8'd0, ST_OK);
      end else if (phase != RX_IDLE) begin
        if (ev_kind == EV_TIMEOUT) begin
          abort_transfer(ST_TIMEOUT);
        end else if (ev_kind == EV_CANCEL) begin
          abort_transfer(ST_CANCELLED);
        end else if (phase == RX_BLOCK) begin
          block_byte(b);
        end else begin
          eot_byte(b);
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) due_replies.push_back(batch[i]);
      return active;
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      failures++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        failures++;
        $display("%0t: result with nothing due, expected none, actual 0x%0h", $time, got);
        return;
      end
      want = due_replies.pop_front();
      if (got.out_kind != want.out_kind)
        report("out_kind", want.out_kind, got.out_kind);
      if (got.payload_byte != want.payload_byte)
        report("payload_byte", want.payload_byte, got.payload_byte);
      if (got.payload_index != want.payload_index)
        report("payload_index", want.payload_index, got.payload_index);
      if (got.tx_byte != want.tx_byte)
        report("tx_byte", want.tx_byte, got.tx_byte);
      if (got.block_number != want.block_number)
        report("block_number", want.block_number, got.block_number);
      if (got.kept_length != want.kept_length)
        report("kept_length", want.kept_length, got.kept_length);
      if (got.end_status != want.end_status)
        report("end_status", want.end_status, got.end_status);
      if (got.last != want.last)
        report("last", want.last, got.last);
    endfunction

    function int pending();
      return due_replies.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  xcrc_item_if   item_ch();
  xcrc_result_if result_ch();
  xcrc_cfg_if    cfg_ch();

  xmodem_crc_block_receiver dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  reply_predictor sb = new();

  // Items that the block acts on; the random part stops once enough have gone in.
  int active_items;
  // While a side is in burst mode it draws no idle cycles at all.
  bit src_burst;
  bit snk_burst;
  int idle_cycles;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Every input of the block is known from time zero.
  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.kind    = EV_BYTE;
    item_ch.rx_byte = 8'd0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_BLOCK_COUNT;
    cfg_ch.data     = 16'd0;
    result_ch.ready = 1'b0;
  end

  // Offers one input item after a random gap and returns right after the rising edge at
  // which it is accepted. Valid stays high until the next falling edge, where it is either
  // given the next item or dropped, so it never gets two assignments in one time step.
  task automatic offer_event(logic [1:0] ev_kind, logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.kind    <= ev_kind;
    item_ch.rx_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (sb.note_event(ev_kind, b)) active_items++;
  endtask

  // Drops the input valid and waits until every predicted result has come out, then a
  // few more cycles so that an item with no result has also left the pipeline.
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is settled.
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sends one frame for the block the receiver expects, mostly well formed. A damaged
  // frame has a bad header byte or CRC, or is cut short by a timeout, cancel or restart.
  task automatic send_frame();
    logic [7:0]   data [PAYLOAD_LEN];
    logic [15:0]  crc;
    logic [7:0]   blk;
    logic [7:0]   b;
    logic         low_first;
    logic [1:0]   cut_kind;
    frame_fault_t fault;
    int           pick;
    int           tail;
    int           cut;
    int           i;
    int           p;
    pick = $urandom_range(0, 99);
    if (pick < 60)      fault = FR_GOOD;
    else if (pick < 66) fault = FR_BAD_SOH;
    else if (pick < 72) fault = FR_BAD_NUM;
    else if (pick < 77) fault = FR_BAD_CPL;
    else if (pick < 85) fault = FR_BAD_CRC;
    else if (pick < 89) fault = FR_SWAP_CRC;
    else if (pick < 93) fault = FR_CUT_TIMEOUT;
    else if (pick < 97) fault = FR_CUT_CANCEL;
    else                fault = FR_CUT_START;

    // Trailing zero padding, sometimes the whole payload, exercises final-block trimming.
    tail = ($urandom_range(0, 2) == 0) ? $urandom_range(0, PAYLOAD_LEN) : 0;
    crc  = 16'd0;
    for (i = 0; i < PAYLOAD_LEN; i++) begin
      data[i] = (i >= PAYLOAD_LEN - tail) ? 8'h00 : 8'($urandom);
      crc     = reply_predictor::crc_step(crc, data[i]);
    end
    if (fault == FR_BAD_CRC) crc = crc ^ 16'(1 << $urandom_range(0, 15));
    low_first = sb.crc_low_first ^ (fault == FR_SWAP_CRC);
    blk       = sb.expected_block[7:0];

    cut = -1;
    cut_kind = EV_TIMEOUT;
    if (fault == FR_CUT_TIMEOUT || fault == FR_CUT_CANCEL || fault == FR_CUT_START) begin
      cut = $urandom_range(0, FRAME_LEN - 1);
      cut_kind = (fault == FR_CUT_CANCEL) ? EV_CANCEL :
                 (fault == FR_CUT_START) ? EV_START : EV_TIMEOUT;
    end

    for (p = 0; p < FRAME_LEN; p++) begin
      // Once enough items have gone in, the frame stops here and the session is aborted.
      if (active_items >= RANDOM_ITEMS) return;
      if (p == cut) begin
        offer_event(cut_kind, 8'($urandom));
        return;
      end
      if (p == 0) begin
        b = CH_SOH;
        if (fault == FR_BAD_SOH) begin
          b = 8'($urandom);
          if (b == CH_SOH) b = CH_EOT;
        end
      end else if (p == 1) begin
        b = blk;
        // A bad number is either the previous block sent again or the complement of the right one.
        if (fault == FR_BAD_NUM) b = ($urandom_range(0, 1) == 0) ? blk - 8'd1 : ~blk;
      end else if (p == 2) begin
        b = ~blk;
        if (fault == FR_BAD_CPL) b = b ^ 8'(1 << $urandom_range(0, 7));
      end else if (p < 3 + PAYLOAD_LEN) begin
        b = data[p - 3];
      end else if (p == 3 + PAYLOAD_LEN) begin
        b = low_first ? crc[7:0] : crc[15:8];
      end else begin
        b = low_first ? crc[15:8] : crc[7:0];
      end
      offer_event(EV_BYTE, b);
    end
  endtask

  // One transfer from start to its end: frames while blocks are due, then an EOT pair
  // (sometimes broken), and a timeout or cancel if it is still going after a few rounds.
  task automatic run_session();
    int rounds;
    int pick;
    offer_event(EV_START, 8'($urandom));
    rounds = 0;
    while (sb.phase != RX_IDLE && rounds < 6 && active_items < RANDOM_ITEMS) begin
      rounds++;
      if (sb.phase == RX_BLOCK) begin
        send_frame();
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          offer_event(EV_BYTE, CH_EOT);
          offer_event(EV_BYTE, CH_EOT);
        end else if (pick == 6) begin
          offer_event(EV_BYTE, 8'($urandom));
          offer_event(EV_BYTE, CH_EOT);
        end else if (pick == 7) begin
          offer_event(EV_BYTE, CH_EOT);
          offer_event(EV_BYTE, 8'($urandom));
        end else if (pick == 8) begin
          offer_event(EV_TIMEOUT, 8'($urandom));
        end else begin
          offer_event(EV_CANCEL, 8'($urandom));
        end
      end
    end
    if (sb.phase != RX_IDLE) begin
      offer_event(($urandom_range(0, 1) == 0) ? EV_TIMEOUT : EV_CANCEL, 8'($urandom));
    end
    // Now and then some line noise reaches the idle receiver.
    if ($urandom_range(0, 3) == 0) offer_event(2'($urandom), 8'($urandom));
  endtask

  // Result side: random ready gaps, one long hold-off once payload is flowing so that the
  // response queue fills and the block stalls its input while the sender keeps offering.
  initial begin
    reply_t got;
    int     gap;
    int     payloads_seen;
    bit     hold_next;
    bit     held_off;
    payloads_seen = 0;
    hold_next     = 1'b0;
    held_off      = 1'b0;
    // Nothing is sampled until reset has been released.
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_next) begin
        hold_next = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
        gap = snk_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      got.out_kind      = result_ch.out_kind;
      got.payload_byte  = result_ch.payload_byte;
      got.payload_index = result_ch.payload_index;
      got.tx_byte       = result_ch.tx_byte;
      got.block_number  = result_ch.block_number;
      got.kept_length   = result_ch.kept_length;
      got.end_status    = result_ch.end_status;
      got.last          = result_ch.last;
      sb.check_reply(got);
      if (!held_off && got.out_kind == RK_PAYLOAD) begin
        payloads_seen++;
        if (payloads_seen == 10) begin
          hold_next = 1'b1;
          held_off  = 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    active_items = 0;
    src_burst    = ($urandom_range(0, 1) == 1);
    snk_burst    = ($urandom_range(0, 1) == 1);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Bytes, timeouts and cancels while idle give nothing.
    offer_event(EV_BYTE, 8'hFF);
    offer_event(EV_BYTE, 8'h00);
    offer_event(EV_TIMEOUT, 8'h5A);
    offer_event(EV_CANCEL, 8'hA5);

    settle();
    write_register(REG_BLOCK_COUNT, 16'd0);
    write_register(REG_SKIP_CRC, 16'd0);
    write_register(REG_CRC_LOW_FIRST, 16'd1);
    // No blocks: the start goes straight to the EOT pair, which ends the transfer.
    offer_event(EV_START, 8'h00);
    offer_event(EV_BYTE, CH_EOT);
    offer_event(EV_BYTE, CH_EOT);
    // A broken EOT pair is rejected with NAKs, then a timeout aborts with CANs.
    offer_event(EV_START, 8'hFF);
    offer_event(EV_BYTE, 8'h00);
    offer_event(EV_BYTE, CH_EOT);
    offer_event(EV_TIMEOUT, 8'h00);

    // With no retries allowed the first broken pair exhausts them.
    settle();
    write_register(REG_RETRY_LIMIT, 16'd0);
    offer_event(EV_START, 8'h00);
    offer_event(EV_BYTE, CH_EOT);
    offer_event(EV_BYTE, 8'hFF);
    offer_event(EV_START, 8'h00);
    offer_event(EV_CANCEL, 8'hFF);

    // A start in the middle of a frame restarts the transfer from block 1.
    settle();
    write_register(REG_BLOCK_COUNT, 16'hFFFF);
    offer_event(EV_START, 8'h00);
    offer_event(EV_BYTE, CH_SOH);
    offer_event(EV_START, 8'h00);
    offer_event(EV_BYTE, CH_SOH);
    offer_event(EV_CANCEL, 8'h00);

    // Random part: whole transfers under a fresh setting each time. The first one always
    // carries blocks so that payload flows early.
    active_items = 0;
    while (active_items < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 99);
      if (active_items == 0 || (pick >= 25 && pick < 60)) begin
        write_register(REG_BLOCK_COUNT, 16'($urandom_range(1, 3)));
      end else if (pick < 25) begin
        write_register(REG_BLOCK_COUNT, 16'd0);
      end else if (pick < 90) begin
        write_register(REG_BLOCK_COUNT, 16'd1);
      end else begin
        write_register(REG_BLOCK_COUNT, ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom));
      end
      write_register(REG_SKIP_CRC, 16'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      write_register(REG_RETRY_LIMIT, (pick < 4) ? 16'd0 :
                                      (pick < 8) ? 16'($urandom_range(1, 3)) : 16'd255);
      write_register(REG_CRC_LOW_FIRST, 16'($urandom_range(0, 1)));
      run_session();
    end

    // Drain: every due result must come out, and nothing more may follow it.
    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/xcrc_pkg.sv
rtl/core/xcrc_if.sv
rtl/core/xcrc_core.sv
rtl/core/xcrc_out_queue.sv
rtl/core/xmodem_crc_block_receiver.sv
bench/tb_top.sv
